// ===== hdl/nmea_pkg.sv =====
// Shared types and constants for the RMC sentence field extractor.
// Used by every module of the block but the checker; no dependencies.
`timescale 1ns / 1ps

package nmea_pkg;

  localparam int FIELD_CAP_DEF  = 16;
  localparam int HEADER_CAP_DEF = 16;
  localparam int QUEUE_DEPTH    = 2;

  localparam int HDR_LEN     = 6;
  localparam int FIELD_TOTAL = 9;
  localparam int POS_W       = 6;
  localparam int FCNT_W      = 4;

  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;

  // "$GPRMC"
  localparam logic [7:0] HDR_TEXT [HDR_LEN] = '{8'h24, 8'h47, 8'h50, 8'h52, 8'h4D, 8'h43};

  typedef enum logic {
    KIND_BYTE    = 1'b0,
    KIND_RESTART = 1'b1
  } kind_t;

  // Classified input transaction as held in the queue
  typedef struct packed {
    kind_t                kind;
    logic [7:0]           data;
    logic                 is_term;
    logic [HDR_LEN-1:0]   hdr_hit;
  } item_t;

  typedef struct packed {
    logic                 store_valid;
    logic [FCNT_W-1:0]    field_index;
    logic [POS_W-1:0]     char_pos;
    logic [7:0]           char_value;
    logic                 field_done;
    logic                 sentence_ready;
  } result_t;

endpackage

// ===== hdl/nmea_front.sv =====
// Front end: input handshake and per-byte classification (terminators,
// header character matches). Depends on nmea_pkg.
`timescale 1ns / 1ps

module nmea_front (
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [7:0]         s_tdata,   // [7:0] data_byte
  input  logic [0:0]         s_tuser,   // [0] kind
  input  logic               q_full,
  output logic               q_wr,
  output nmea_pkg::item_t    q_item
);

  logic [nmea_pkg::HDR_LEN-1:0] hit;

  always_comb begin
    for (int i = 0; i < nmea_pkg::HDR_LEN; i++) begin
      hit[i] = (s_tdata == nmea_pkg::HDR_TEXT[i]);
    end
  end

  assign s_tready = !q_full;
  assign q_wr     = s_tvalid && !q_full;

  assign q_item.kind    = nmea_pkg::kind_t'(s_tuser[0]);
  assign q_item.data    = s_tdata;
  assign q_item.is_term = (s_tdata == nmea_pkg::CH_COMMA) || (s_tdata == nmea_pkg::CH_LF) ||
                          (s_tdata == nmea_pkg::CH_CR);
  assign q_item.hdr_hit = hit;

endmodule

// ===== hdl/nmea_queue.sv =====
// Short FIFO of classified items between front and back end.
// Depends on nmea_pkg.
`timescale 1ns / 1ps

module nmea_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr,
  input  nmea_pkg::item_t  wr_item,
  output logic             full,
  input  logic             rd,
  output logic             valid,
  output nmea_pkg::item_t  rd_item
);

  localparam int DEPTH = nmea_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  nmea_pkg::item_t   slots [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;

  assign full    = (count == CNT_FULL);
  assign valid   = (count != '0);
  assign rd_item = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      slots[wr_ptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (rd) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (wr && !rd) begin
        count <= count + 1'b1;
      end else if (rd && !wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== hdl/nmea_back.sv =====
// Back end: tokenizer / sentence state and the registered result stage.
// Depends on nmea_pkg.
`timescale 1ns / 1ps

module nmea_back #(
  parameter int FIELD_CAP  = nmea_pkg::FIELD_CAP_DEF,
  parameter int HEADER_CAP = nmea_pkg::HEADER_CAP_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  nmea_pkg::item_t  q_item,
  output logic             q_rd,
  output logic             m_tvalid,
  input  logic             m_tready,
  output nmea_pkg::result_t res
);

  localparam int POS_W = nmea_pkg::POS_W;
  localparam int FCNT_W = nmea_pkg::FCNT_W;
  localparam logic [POS_W-1:0]  FIELD_LAST = POS_W'(FIELD_CAP - 1);
  localparam logic [POS_W-1:0]  HDR_LAST   = POS_W'(HEADER_CAP - 1);
  localparam logic [POS_W-1:0]  HDR_END    = POS_W'(nmea_pkg::HDR_LEN);
  localparam logic [FCNT_W-1:0] FTOTAL     = FCNT_W'(nmea_pkg::FIELD_TOTAL);

  logic              capturing,    capturing_next;
  logic              header_seen,  header_seen_next;
  logic [FCNT_W-1:0] field_count,  field_count_next;
  logic [POS_W-1:0]  token_pos,    token_pos_next;
  logic              header_match, header_match_next;
  nmea_pkg::result_t res_next;

  logic in_field;
  logic ends;
  logic hit_at_pos;

  assign q_rd = q_valid && (!m_tvalid || m_tready);

  always_comb begin
    hit_at_pos = 1'b0;
    for (int i = 0; i < nmea_pkg::HDR_LEN; i++) begin
      if (token_pos == POS_W'(i)) begin
        hit_at_pos = q_item.hdr_hit[i];
      end
    end
  end

  assign in_field = header_seen && (field_count >= FCNT_W'(1)) && (field_count <= FTOTAL);
  assign ends     = q_item.is_term ||
                    (token_pos == (header_seen ? FIELD_LAST : HDR_LAST));

  always_comb begin
    capturing_next    = capturing;
    header_seen_next  = header_seen;
    field_count_next  = field_count;
    token_pos_next    = token_pos;
    header_match_next = header_match;
    res_next          = '0;

    if (q_item.kind == nmea_pkg::KIND_RESTART) begin
      capturing_next    = 1'b1;
      header_seen_next  = 1'b0;
      field_count_next  = '0;
      token_pos_next    = '0;
      header_match_next = 1'b1;
    end else if (capturing) begin
      if (in_field) begin
        res_next.field_index = field_count - 1'b1;
        res_next.char_pos    = token_pos;
      end
      if (!ends) begin
        header_match_next = header_match && (token_pos < HDR_END) && hit_at_pos;
        token_pos_next    = token_pos + 1'b1;
        if (in_field) begin
          res_next.store_valid = 1'b1;
          res_next.char_value  = q_item.data;
        end
      end else begin
        res_next.field_done = in_field;
        if (header_match && (token_pos == HDR_END)) begin
          // header token restarts the sentence from any field
          header_seen_next = 1'b1;
          field_count_next = FCNT_W'(1);
        end else if (header_seen) begin
          if (field_count >= FTOTAL) begin
            capturing_next = 1'b0;
          end
          field_count_next = field_count + 1'b1;
        end
        token_pos_next    = '0;
        header_match_next = 1'b1;
      end
    end
    res_next.sentence_ready = !capturing_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capturing    <= 1'b1;
      header_seen  <= 1'b0;
      field_count  <= '0;
      token_pos    <= '0;
      header_match <= 1'b1;
      m_tvalid     <= 1'b0;
    end else begin
      if (q_rd) begin
        capturing    <= capturing_next;
        header_seen  <= header_seen_next;
        field_count  <= field_count_next;
        token_pos    <= token_pos_next;
        header_match <= header_match_next;
        m_tvalid     <= 1'b1;
      end else if (m_tready) begin
        m_tvalid     <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_rd) begin
      res <= res_next;
    end
  end

endmodule

// ===== hdl/nmea_rmc_field_extractor.sv =====
// Top level of the RMC sentence field extractor.
// Depends on nmea_pkg, nmea_front, nmea_queue, nmea_back.
//
// Usage:
//   Slave stream: one transaction per received serial byte (s_tuser[0] = 0,
//   byte in s_tdata) or a capture restart (s_tuser[0] = 1, s_tdata ignored).
//   Master stream: exactly one result per input transaction, in order.
//   m_tuser[0] flags a character to store at (field_index, char_pos) with
//   value char_value; m_tlast marks a byte that closed a captured field;
//   m_tuser[1] is sentence_ready, held once the date field has ended until
//   a restart transaction arrives.
// Path: an accepted input is written into the queue, then read out into the
//   registered result on m_tvalid when the output is not stalled.
// Throughput: 1 transaction per cycle while m_tready does not stall the output;
//   the back end updates its state once per byte it reads from the queue.
// Reset (rst, synchronous): queue emptied, no result pending, capture
//   armed and waiting for the "$GPRMC" header.
// Stall: a low m_tready keeps the result registered; the two-entry queue
//   keeps accepting input until it fills, then s_tready drops.
`timescale 1ns / 1ps

module nmea_rmc_field_extractor #(
  parameter int FIELD_CAP  = nmea_pkg::FIELD_CAP_DEF,
  parameter int HEADER_CAP = nmea_pkg::HEADER_CAP_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic [0:0]  s_tuser,   // [0] kind
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [3:0] field_index, [9:4] char_pos, [17:10] char_value
  output logic        m_tlast,   // field_done
  output logic [1:0]  m_tuser    // [0] store_valid, [1] sentence_ready
);

  nmea_pkg::item_t   wr_item;
  nmea_pkg::item_t   rd_item;
  nmea_pkg::result_t res;
  logic              q_full;
  logic              q_wr;
  logic              q_rd;
  logic              q_valid;

  nmea_front u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_full   (q_full),
    .q_wr     (q_wr),
    .q_item   (wr_item)
  );

  nmea_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (q_wr),
    .wr_item (wr_item),
    .full    (q_full),
    .rd      (q_rd),
    .valid   (q_valid),
    .rd_item (rd_item)
  );

  nmea_back #(
    .FIELD_CAP  (FIELD_CAP),
    .HEADER_CAP (HEADER_CAP)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_item   (rd_item),
    .q_rd     (q_rd),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .res      (res)
  );

  assign m_tdata = {6'd0, res.char_value, res.char_pos, res.field_index};
  assign m_tlast = res.field_done;
  assign m_tuser = {res.sentence_ready, res.store_valid};

endmodule

// ===== hdl/nmea_checker.sv =====
// Port-level checks for the RMC sentence field extractor, bound to the top.
// Depends on nmea_rmc_field_extractor ports only.
`timescale 1ns / 1ps

module nmea_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata,
  input logic        m_tlast,
  input logic [1:0]  m_tuser
);

  // stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // no result can be pending right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

  // a stored char belongs to an open field, and is neither a terminator nor a ready result
  a_store_kind: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> (m_tdata[3:0] <= 4'd8) && !m_tlast && !m_tuser[1])
    else $error("inconsistent store result");

  // a stored char never sits at position 63, the last one the 6-bit char_pos can hold
  a_store_pos: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata[9:4] != 6'd63)
    else $error("store position out of range");

endmodule

bind nmea_rmc_field_extractor nmea_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast),
  .m_tuser  (m_tuser)
);

// ===== dv/tb_nmea_rmc_field_extractor.sv =====
// Self-checking testbench for nmea_rmc_field_extractor: directed table, then random sentences and random bursts.
// Expected results come from a cycle-free model of the parser state kept in this file.
// Depends on nmea_pkg and the RTL top level only.
`timescale 1ns / 1ps

module tb_nmea_rmc_field_extractor;
  import nmea_pkg::*;

  localparam int FIELD_CAP    = FIELD_CAP_DEF;
  localparam int HEADER_CAP   = HEADER_CAP_DEF;
  localparam int ITEMS_TARGET = 1750;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int HOLD_CYCLES  = 80;
  localparam int DRAIN_CYCLES = 8;

  typedef struct packed {
    kind_t   k;
    logic [7:0] ch;
    logic    typed;  // 1: want is typed in below, else the parser model decides
    result_t want;
  } step_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;   // [7:0] data_byte
  logic [0:0]  s_tuser = 1'b0;    // [0] kind
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;           // [3:0] field_index, [9:4] char_pos, [17:10] char_value
  logic        m_tlast;           // field_done
  logic [1:0]  m_tuser;           // [0] store_valid, [1] sentence_ready

  // Parser state as seen by the checker
  logic       cap_active;
  logic       hdr_found;
  logic [3:0] fld_cnt;
  logic [5:0] tok_pos;
  logic       hdr_prefix_ok;

  result_t    rmc_results_q[$];
  result_t    got_exp;
  int         mismatches = 0;
  int         sent_total = 0;
  int         live_items = 0;
  int         results_seen = 0;
  int         stores_seen = 0;
  int         fields_closed = 0;
  int         sentences_done = 0;
  int         cycles = 0;
  int         hold_left = 0;
  bit         hold_req = 1'b0;
  bit         hold_used = 1'b0;
  bit         drained = 1'b0;
  bit         steady = 1'b0;

  step_row_t directed_rows [29] = '{
    '{KIND_BYTE,    8'h00, 1'b1, '0},
    '{KIND_RESTART, 8'hFF, 1'b1, '0},
    '{KIND_BYTE,    8'h24, 1'b1, '0},
    '{KIND_BYTE,    8'h47, 1'b1, '0},
    '{KIND_BYTE,    8'h50, 1'b1, '0},
    '{KIND_BYTE,    8'h52, 1'b1, '0},
    '{KIND_BYTE,    8'h4D, 1'b1, '0},
    '{KIND_BYTE,    8'h43, 1'b1, '0},
    '{KIND_BYTE,    CH_COMMA, 1'b1, '0},  // header token: no field_done
    '{KIND_BYTE,    8'hFF, 1'b1, '{1'b1, 4'd0, 6'd0, 8'hFF, 1'b0, 1'b0}},
    '{KIND_BYTE,    CH_COMMA, 1'b1, '{1'b0, 4'd0, 6'd1, 8'h00, 1'b1, 1'b0}},
    // header text inside field 1 is stored, then its terminator restarts at field 0
    '{KIND_BYTE,    8'h24, 1'b0, '0},
    '{KIND_BYTE,    8'h47, 1'b0, '0},
    '{KIND_BYTE,    8'h50, 1'b0, '0},
    '{KIND_BYTE,    8'h52, 1'b0, '0},
    '{KIND_BYTE,    8'h4D, 1'b0, '0},
    '{KIND_BYTE,    8'h43, 1'b0, '0},
    '{KIND_BYTE,    CH_CR, 1'b1, '{1'b0, 4'd1, 6'd6, 8'h00, 1'b1, 1'b0}},
    '{KIND_BYTE,    CH_LF, 1'b1, '{1'b0, 4'd0, 6'd0, 8'h00, 1'b1, 1'b0}},
    '{KIND_BYTE,    CH_COMMA, 1'b1, '{1'b0, 4'd1, 6'd0, 8'h00, 1'b1, 1'b0}},
    '{KIND_BYTE,    CH_CR, 1'b1, '{1'b0, 4'd2, 6'd0, 8'h00, 1'b1, 1'b0}},
    '{KIND_BYTE,    CH_COMMA, 1'b1, '{1'b0, 4'd3, 6'd0, 8'h00, 1'b1, 1'b0}},
    '{KIND_BYTE,    CH_COMMA, 1'b1, '{1'b0, 4'd4, 6'd0, 8'h00, 1'b1, 1'b0}},
    '{KIND_BYTE,    CH_LF, 1'b1, '{1'b0, 4'd5, 6'd0, 8'h00, 1'b1, 1'b0}},
    '{KIND_BYTE,    CH_COMMA, 1'b1, '{1'b0, 4'd6, 6'd0, 8'h00, 1'b1, 1'b0}},
    '{KIND_BYTE,    CH_COMMA, 1'b1, '{1'b0, 4'd7, 6'd0, 8'h00, 1'b1, 1'b0}},
    '{KIND_BYTE,    CH_COMMA, 1'b1, '{1'b0, 4'd8, 6'd0, 8'h00, 1'b1, 1'b1}},
    '{KIND_BYTE,    8'h58, 1'b1, '{1'b0, 4'd0, 6'd0, 8'h00, 1'b0, 1'b1}},
    '{KIND_RESTART, 8'h00, 1'b1, '0}
  };

  nmea_rmc_field_extractor #(
    .FIELD_CAP (FIELD_CAP),
    .HEADER_CAP(HEADER_CAP)
  ) uut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast),
    .m_tuser (m_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void rmc_clear();
    cap_active    = 1'b1;
    hdr_found     = 1'b0;
    fld_cnt       = '0;
    tok_pos       = '0;
    hdr_prefix_ok = 1'b1;
  endfunction

  // One byte or restart through the parser; returns the result it causes.
  function automatic result_t rmc_step(kind_t k, logic [7:0] ch);
    result_t r;
    int      lim;
    logic    in_fld;
    logic    term;
    r = '0;
    if (k == KIND_RESTART) begin
      rmc_clear();
    end else if (cap_active) begin
      lim    = hdr_found ? FIELD_CAP : HEADER_CAP;
      in_fld = hdr_found && fld_cnt >= 1 && fld_cnt <= FIELD_TOTAL;
      // a byte landing on the last slot is dropped and closes the token
      term   = (tok_pos == lim - 1) || ch == CH_COMMA || ch == CH_LF || ch == CH_CR;
      if (in_fld) begin
        r.field_index = fld_cnt - 4'd1;
        r.char_pos    = tok_pos;
      end
      if (!term) begin
        hdr_prefix_ok = hdr_prefix_ok && tok_pos < HDR_LEN &&
                        ch == HDR_TEXT[(tok_pos < HDR_LEN) ? tok_pos : 0];
        tok_pos = tok_pos + 6'd1;
        if (in_fld) begin
          r.store_valid = 1'b1;
          r.char_value  = ch;
        end
      end else begin
        r.field_done = in_fld;
        if (hdr_prefix_ok && tok_pos == HDR_LEN) begin
          hdr_found = 1'b1;
          fld_cnt   = 4'd1;
        end else if (hdr_found) begin
          if (fld_cnt >= FIELD_TOTAL) cap_active = 1'b0;
          fld_cnt = fld_cnt + 4'd1;
        end
        tok_pos       = '0;
        hdr_prefix_ok = 1'b1;
      end
    end
    r.sentence_ready = !cap_active;
    return r;
  endfunction

  function automatic logic [7:0] plain_byte();
    logic [7:0] ch;
    do ch = 8'($urandom_range(255)); while (ch == CH_COMMA || ch == CH_LF || ch == CH_CR);
    return ch;
  endfunction

  function automatic logic [7:0] term_byte();
    int sel;
    sel = $urandom_range(9);
    return (sel == 0) ? CH_CR : (sel == 1) ? CH_LF : CH_COMMA;
  endfunction

  task automatic push_item(kind_t k, logic [7:0] ch, logic typed = 1'b0,
                           result_t want = '0);
    result_t pred;
    logic    live;
    if (!steady) begin
      while ($urandom_range(99) < 23) begin
        s_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tuser  <= k;
    s_tdata  <= ch;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    // bytes after ready are only dropped, so they do not count as work
    live = (k == KIND_RESTART) || cap_active;
    pred = rmc_step(k, ch);
    rmc_results_q.push_back(typed ? want : pred);
    sent_total++;
    if (live) live_items++;
  endtask

  task automatic send_sentence();
    int sel;
    int len;
    int bad_i;
    logic [7:0] ch;
    sel = $urandom_range(99);
    if (sel < 30) begin
      repeat ($urandom_range(1, 4)) push_item(KIND_BYTE, 8'($urandom_range(255)));
      push_item(KIND_BYTE, CH_COMMA);
    end else if (sel < 38) begin
      // junk that fills or overruns the header token capacity
      repeat ($urandom_range(15, 20)) push_item(KIND_BYTE, plain_byte());
      push_item(KIND_BYTE, CH_COMMA);
    end
    sel   = $urandom_range(99);
    bad_i = $urandom_range(HDR_LEN - 1);
    for (int i = 0; i < HDR_LEN; i++) begin
      ch = HDR_TEXT[i];
      if (sel < 8 && i == bad_i) ch = plain_byte();
      if (sel >= 8 && sel < 12 && i == bad_i && i > 0) break;  // truncated header
      push_item(KIND_BYTE, ch);
    end
    if (sel >= 12 && sel < 15) push_item(KIND_BYTE, HDR_TEXT[HDR_LEN-1]);
    push_item(KIND_BYTE, term_byte());
    for (int f = 0; f < FIELD_TOTAL; f++) begin
      sel = $urandom_range(99);
      if (sel < 2) begin
        push_item(KIND_RESTART, 8'($urandom_range(255)));
        return;
      end
      if (sel < 5) begin
        for (int i = 0; i < HDR_LEN; i++) push_item(KIND_BYTE, HDR_TEXT[i]);
      end else begin
        len = (sel < 85) ? $urandom_range(0, 8) :
              (sel < 95) ? $urandom_range(9, 14) : $urandom_range(15, 20);
        repeat (len)
          push_item(KIND_BYTE,
                    ($urandom_range(99) < 95) ? plain_byte() : 8'($urandom_range(255)));
      end
      push_item(KIND_BYTE, term_byte());
    end
    repeat ($urandom_range(0, 3)) push_item(KIND_BYTE, 8'($urandom_range(255)));
    push_item(KIND_RESTART, 8'($urandom_range(255)));
  endtask

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // Result checker and output-side flow control
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (rmc_results_q.size() == 0) begin
        $error("result transaction with none expected: tdata=%h tlast=%b tuser=%b",
               m_tdata, m_tlast, m_tuser);
        mismatches++;
      end else begin
        got_exp = rmc_results_q.pop_front();
        check_field("store_valid", 32'(got_exp.store_valid), 32'(m_tuser[0]));
        check_field("field_index", 32'(got_exp.field_index), 32'(m_tdata[3:0]));
        check_field("char_pos", 32'(got_exp.char_pos), 32'(m_tdata[9:4]));
        check_field("char_value", 32'(got_exp.char_value), 32'(m_tdata[17:10]));
        check_field("field_done", 32'(got_exp.field_done), 32'(m_tlast));
        check_field("sentence_ready", 32'(got_exp.sentence_ready), 32'(m_tuser[1]));
        check_field("tdata_pad", 0, 32'(m_tdata[23:18]));
        stores_seen    += m_tuser[0];
        fields_closed  += m_tlast;
        sentences_done += (m_tlast && m_tuser[1]);
      end
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (hold_req && !hold_used) begin
      hold_used = 1'b1;
      hold_left = HOLD_CYCLES;
      m_tready <= 1'b0;
    end else begin
      m_tready <= steady || ($urandom_range(99) >= 23);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding",
               cycles, rmc_results_q.size());
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    rmc_clear();
    rst <= 1'b1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      push_item(directed_rows[i].k, directed_rows[i].ch, directed_rows[i].typed,
                directed_rows[i].want);

    while (live_items < ITEMS_TARGET) begin
      if (!hold_req && sent_total > 400) hold_req = 1'b1;
      if (!drained && sent_total > 900) begin
        drained = 1'b1;
        while (rmc_results_q.size() != 0) begin
          s_tvalid <= 1'b0;
          @(posedge clk);
        end
      end
      steady = (sent_total > 1100 && sent_total < 1400);
      if ($urandom_range(99) < 10) begin
        repeat ($urandom_range(1, 10))
          push_item(($urandom_range(7) == 0) ? KIND_RESTART : KIND_BYTE,
                    8'($urandom_range(255)));
      end else begin
        send_sentence();
      end
    end
    steady = 1'b0;

    s_tvalid <= 1'b0;
    while (rmc_results_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d transactions (%0d parsed), checked %0d results", sent_total,
             live_items, results_seen);
    $display("Saw %0d stored chars, %0d closed fields, %0d full sentences", stores_seen,
             fields_closed, sentences_done);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/nmea_pkg.sv
hdl/nmea_front.sv
hdl/nmea_queue.sv
hdl/nmea_back.sv
hdl/nmea_rmc_field_extractor.sv
hdl/nmea_checker.sv
dv/tb_nmea_rmc_field_extractor.sv
